[rtl/csv_row_filter_defines.svh]
// Assertion macros shared by the RTL of the CSV row filter.
`ifndef CSV_ROW_FILTER_DEFINES_SVH
`define CSV_ROW_FILTER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is high.
`define CSVRF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csv_row_filter assertion failed");
// Next-cycle implication, disabled while reset is high.
`define CSVRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csv_row_filter assertion failed");
`else
`define CSVRF_ASSERT_IMP(label, clk, rst, ante, cons)
`define CSVRF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/csvrf_pkg.sv]
`default_nettype none

package csvrf_pkg;

   localparam int CHAR_W       = 8;
   localparam int COLUMN_W     = 7;
   localparam int LENGTH_W     = 4;
   localparam int COUNT_W      = 3;
   localparam int FILTER_SLOTS = 4;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int RSP_COUNT_W  = 7;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_COMMA   = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_QUOTE   = 8'h22;
   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FILTER_COUNT   = 3'd0,
      CSR_FILTER_COLUMNS = 3'd1,
      CSR_FILTER_LENGTHS = 3'd2,
      CSR_FILTER_TEXT_A  = 3'd3,
      CSR_FILTER_TEXT_B  = 3'd4,
      CSR_FILTER_TEXT_C  = 3'd5,
      CSR_FILTER_TEXT_D  = 3'd6
   } csr_index_type;

   // Outside quotes, inside quotes, and inside quotes right after a quote.
   typedef enum logic [2:0] {
      QM_OUTSIDE = 3'b001,
      QM_INSIDE  = 3'b010,
      QM_AFTER   = 3'b100
   } quote_mode_type;

endpackage

`default_nettype wire

[rtl/csv_row_filter.sv]
// An accepted byte goes into the input register; a row result that it ends goes
// to the result register. Throughput: one byte per cycle unless the result register is stalled;
// the per-byte parser and filter window update between these two registers sets this.
// Reset is synchronous and active high. It clears the parser state, the filter
// registers and both handshake stages.
`default_nettype none

`include "csv_row_filter_defines.svh"

module csv_row_filter
   import csvrf_pkg::*;
#(
   parameter int MAX_FIELDS   = 64,
   parameter int FIELD_CHARS  = 64,
   parameter int NUM_FILTERS  = 4,
   parameter int FILTER_CHARS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [CHAR_W-1:0]      req_data_byte,
   input  logic                   req_end_of_input,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_keep_row,
   output logic [RSP_COUNT_W-1:0] rsp_column_count,
   output logic                   rsp_ended_by_input_end,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FI_W  = $clog2(MAX_FIELDS + 1);
   localparam int FL_W  = $clog2(FIELD_CHARS + 1);
   localparam int CMP_W = (FI_W > COLUMN_W) ? FI_W : COLUMN_W;
   localparam int WIN_W = FILTER_CHARS * CHAR_W;

   // Filter registers.
   logic [COUNT_W-1:0]                  filter_count_ff;
   logic [FILTER_SLOTS*COLUMN_W-1:0]    filter_columns_ff;
   logic [FILTER_SLOTS*LENGTH_W-1:0]    filter_lengths_ff;
   logic [CSR_DATA_W-1:0]               filter_text_ff [FILTER_SLOTS];

   // Input stage.
   logic                in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0]   in_byte_ff;
   logic                in_eoi_ff;

   // Parser state.
   quote_mode_type          quote_ff, quote_in;
   logic [FI_W-1:0]         field_idx_ff, field_idx_in;
   logic [FL_W-1:0]         field_len_ff, field_len_in;
   logic [WIN_W-1:0]        recent_ff, recent_in;
   logic [NUM_FILTERS-1:0]  found_ff, found_in;
   logic                    row_started_ff, row_started_in;

   // Result stage.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_keep_ff, rsp_keep_in;
   logic [RSP_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                   rsp_eoi_ff, rsp_eoi_in;

   logic advance, proceed, accept;

   // Byte decode.
   logic                row_end, by_eoi, field_end, do_store;
   logic [CHAR_W-1:0]   store_char;
   quote_mode_type      qm_eff, qm_next;

   // Store path.
   logic                    stored, field_counted;
   logic [FL_W-1:0]         new_len;
   logic [WIN_W-1:0]        window_shift;
   logic [NUM_FILTERS-1:0]  found_set;
   logic [CMP_W-1:0]        idx_ext, count_ext;
   logic [FI_W-1:0]         count_idx;
   logic                    keep;

   function automatic logic [LENGTH_W-1:0] clamp_len(input logic [LENGTH_W-1:0] raw);
      if (raw > LENGTH_W'(FILTER_CHARS)) begin
         return LENGTH_W'(FILTER_CHARS);
      end
      return raw;
   endfunction

   // True when the first len filter characters equal the newest len window bytes.
   function automatic logic window_hit(input logic [CSR_DATA_W-1:0] text,
                                       input logic [WIN_W-1:0]      win,
                                       input logic [LENGTH_W-1:0]   len);
      logic hit;
      logic all_eq;
      hit = 1'b0;
      for (int n = 1; n <= FILTER_CHARS; n++) begin
         all_eq = 1'b1;
         for (int i = 0; i < n; i++) begin
            if (text[CHAR_W*i +: CHAR_W] != win[CHAR_W*(n-1-i) +: CHAR_W]) begin
               all_eq = 1'b0;
            end
         end
         if (len == LENGTH_W'(n) && all_eq) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   // The result register frees up when it is empty or its word is taken.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign proceed   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      row_end    = 1'b0;
      by_eoi     = 1'b0;
      field_end  = 1'b0;
      do_store   = 1'b0;
      store_char = in_byte_ff;
      qm_eff     = quote_ff;
      qm_next    = quote_ff;
      if (in_eoi_ff) begin
         if (row_started_ff) begin
            row_end = 1'b1;
            by_eoi  = 1'b1;
         end
      end else if (quote_ff == QM_AFTER && in_byte_ff == CHAR_NEWLINE) begin
         row_end = 1'b1;
      end else if (quote_ff == QM_AFTER && in_byte_ff == CHAR_QUOTE) begin
         // A doubled quote stores one literal quote.
         do_store   = 1'b1;
         store_char = CHAR_QUOTE;
         qm_next    = QM_INSIDE;
      end else begin
         if (quote_ff == QM_AFTER) begin
            qm_eff = QM_OUTSIDE;
         end
         qm_next = qm_eff;
         if (in_byte_ff == CHAR_NEWLINE) begin
            row_end = 1'b1;
         end else if (in_byte_ff == CHAR_COMMA && qm_eff == QM_OUTSIDE) begin
            field_end = 1'b1;
         end else if (in_byte_ff == CHAR_QUOTE) begin
            qm_next = (qm_eff == QM_OUTSIDE) ? QM_INSIDE : QM_AFTER;
         end else if (in_byte_ff != CHAR_NUL) begin
            do_store = 1'b1;
         end
      end
   end

   always_comb begin
      stored        = do_store && (field_len_ff < FL_W'(FIELD_CHARS));
      new_len       = field_len_ff + FL_W'(1);
      field_counted = field_idx_ff < FI_W'(MAX_FIELDS);
      idx_ext       = CMP_W'(field_idx_ff);
      count_idx     = field_counted ? field_idx_ff + FI_W'(1) : field_idx_ff;
      count_ext     = CMP_W'(count_idx);
      window_shift[CHAR_W-1:0] = store_char;
      for (int k = 1; k < FILTER_CHARS; k++) begin
         window_shift[CHAR_W*k +: CHAR_W] = recent_ff[CHAR_W*(k-1) +: CHAR_W];
      end
      keep = 1'b1;
      for (int j = 0; j < NUM_FILTERS; j++) begin
         found_set[j] = stored && field_counted
            && CMP_W'(filter_columns_ff[COLUMN_W*j +: COLUMN_W]) == idx_ext
            && clamp_len(filter_lengths_ff[LENGTH_W*j +: LENGTH_W]) != '0
            && FL_W'(clamp_len(filter_lengths_ff[LENGTH_W*j +: LENGTH_W])) <= new_len
            && window_hit(filter_text_ff[j], window_shift,
                          clamp_len(filter_lengths_ff[LENGTH_W*j +: LENGTH_W]));
         // A filter whose column exceeds MAX_FIELDS is ignored.
         if (COUNT_W'(j) < filter_count_ff
             && CMP_W'(filter_columns_ff[COLUMN_W*j +: COLUMN_W]) <= CMP_W'(MAX_FIELDS)) begin
            if (CMP_W'(filter_columns_ff[COLUMN_W*j +: COLUMN_W]) >= count_ext) begin
               keep = 1'b0;
            end
            if (clamp_len(filter_lengths_ff[LENGTH_W*j +: LENGTH_W]) != '0 && !found_ff[j]) begin
               keep = 1'b0;
            end
         end
      end
   end

   always_comb begin
      quote_in       = quote_ff;
      field_idx_in   = field_idx_ff;
      field_len_in   = field_len_ff;
      recent_in      = recent_ff;
      found_in       = found_ff;
      row_started_in = row_started_ff;
      if (proceed) begin
         if (row_end) begin
            quote_in       = QM_OUTSIDE;
            field_idx_in   = '0;
            field_len_in   = '0;
            recent_in      = '0;
            found_in       = '0;
            row_started_in = 1'b0;
         end else if (!in_eoi_ff) begin
            row_started_in = 1'b1;
            quote_in       = qm_next;
            if (field_end) begin
               field_idx_in = count_idx;
               field_len_in = '0;
               recent_in    = '0;
               quote_in     = QM_OUTSIDE;
            end else if (stored) begin
               field_len_in = new_len;
               recent_in    = window_shift;
               found_in     = found_ff | found_set;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_keep_in  = rsp_keep_ff;
      rsp_count_in = rsp_count_ff;
      rsp_eoi_in   = rsp_eoi_ff;
      if (advance) begin
         rsp_valid_in = proceed && row_end;
         rsp_keep_in  = keep;
         rsp_count_in = count_ext[RSP_COUNT_W-1:0];
         rsp_eoi_in   = by_eoi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_count_ff   <= '0;
         filter_columns_ff <= '0;
         filter_lengths_ff <= '0;
         for (int k = 0; k < FILTER_SLOTS; k++) begin
            filter_text_ff[k] <= '0;
         end
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_FILTER_COUNT:   filter_count_ff   <= csr_wdata[COUNT_W-1:0];
            CSR_FILTER_COLUMNS: filter_columns_ff <= csr_wdata[FILTER_SLOTS*COLUMN_W-1:0];
            CSR_FILTER_LENGTHS: filter_lengths_ff <= csr_wdata[FILTER_SLOTS*LENGTH_W-1:0];
            CSR_FILTER_TEXT_A:  filter_text_ff[0] <= csr_wdata;
            CSR_FILTER_TEXT_B:  filter_text_ff[1] <= csr_wdata;
            CSR_FILTER_TEXT_C:  filter_text_ff[2] <= csr_wdata;
            CSR_FILTER_TEXT_D:  filter_text_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         quote_ff       <= QM_OUTSIDE;
         field_idx_ff   <= '0;
         field_len_ff   <= '0;
         recent_ff      <= '0;
         found_ff       <= '0;
         row_started_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         quote_ff       <= quote_in;
         field_idx_ff   <= field_idx_in;
         field_len_ff   <= field_len_in;
         recent_ff      <= recent_in;
         found_ff       <= found_in;
         row_started_ff <= row_started_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_data_byte;
         in_eoi_ff  <= req_end_of_input;
      end
      rsp_keep_ff  <= rsp_keep_in;
      rsp_count_ff <= rsp_count_in;
      rsp_eoi_ff   <= rsp_eoi_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_keep_row           = rsp_keep_ff;
   assign rsp_column_count       = rsp_count_ff;
   assign rsp_ended_by_input_end = rsp_eoi_ff;

   `CSVRF_ASSERT_NEXT(a_row_end_clears, clock, reset, proceed && row_end,
      field_idx_ff == '0 && field_len_ff == '0 && found_ff == '0 && !row_started_ff)
   `CSVRF_ASSERT_IMP(a_found_needs_row, clock, reset, found_ff != '0, row_started_ff)
   `CSVRF_ASSERT_IMP(a_len_needs_row, clock, reset, field_len_ff != '0, row_started_ff)
   `CSVRF_ASSERT_IMP(a_stall_needs_word, clock, reset, req_stall, in_valid_ff)
   `CSVRF_ASSERT_IMP(a_result_from_word, clock, reset, $rose(rsp_valid_ff), $past(in_valid_ff))

endmodule

`default_nettype wire
